// File: rtl/core/bsfs_pkg.sv
`default_nettype none

package bsfs_pkg;

    localparam int MAX_SEGMENTS    = 256;
    localparam int SEG_IDX_W       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int COUNT_W         = $clog2(MAX_SEGMENTS + 1);
    localparam int COORD_FRAC_BITS = 24;
    localparam int COORD_W         = 32;
    localparam int INDEX_W         = 8;
    localparam int CFG_W           = 9;
    localparam int FIELD_W         = 48;
    localparam int VEC_W           = COORD_W + 2;
    localparam int QUEUE_DEPTH     = 2;
    localparam int APB_DATA_W      = 32;
    localparam int PADDR_W         = 3;

    localparam logic [PADDR_W-3:0] REG_SEGMENTS_IN_USE = '0;
    localparam logic [CFG_W-1:0]   SEGMENTS_RESET      = CFG_W'(1);

    typedef enum logic [1:0] {
        ITEM_LOAD,
        ITEM_EVAL,
        ITEM_DROP
    } item_kind_t;

    typedef struct packed {
        item_kind_t                kind;
        logic [INDEX_W-1:0]        idx;
        logic signed [VEC_W-1:0]   ax;
        logic signed [VEC_W-1:0]   ay;
        logic signed [VEC_W-1:0]   az;
        logic signed [VEC_W-1:0]   bx;
        logic signed [VEC_W-1:0]   by;
        logic signed [VEC_W-1:0]   bz;
    } work_item_t;

    typedef struct packed {
        logic signed [VEC_W-1:0]   dir_x;
        logic signed [VEC_W-1:0]   dir_y;
        logic signed [VEC_W-1:0]   dir_z;
        logic signed [VEC_W-1:0]   mid_x;
        logic signed [VEC_W-1:0]   mid_y;
        logic signed [VEC_W-1:0]   mid_z;
    } seg_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_MAG,
        S_MAX,
        S_NORM,
        S_APPLY,
        S_MUL,
        S_SQRT,
        S_CUBE1,
        S_CUBE2,
        S_DIV,
        S_SCALE,
        S_SHIFT,
        S_FINISH
    } engine_state_t;

endpackage

`default_nettype wire

// File: rtl/core/bsfs_front.sv
`default_nettype none

module bsfs_front
    import bsfs_pkg::*;
(
    input  logic                      mode,
    input  logic [INDEX_W-1:0]        seg_index,
    input  logic signed [COORD_W-1:0] end_ax,
    input  logic signed [COORD_W-1:0] end_bx,
    input  logic signed [COORD_W-1:0] end_ay,
    input  logic signed [COORD_W-1:0] end_by,
    input  logic signed [COORD_W-1:0] end_az,
    input  logic signed [COORD_W-1:0] end_bz,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    output work_item_t                item
);

    localparam int IDX_CMP_W = INDEX_W + COUNT_W;

    logic in_range;

    assign in_range = IDX_CMP_W'(seg_index) < IDX_CMP_W'(MAX_SEGMENTS);

    always_comb
    begin
        item.idx = seg_index;
        if (mode)
        begin
            // The point is doubled so that it shares units with the stored end sums.
            item.kind = ITEM_EVAL;
            item.ax   = VEC_W'(point_x) <<< 1;
            item.ay   = VEC_W'(point_y) <<< 1;
            item.az   = VEC_W'(point_z) <<< 1;
            item.bx   = '0;
            item.by   = '0;
            item.bz   = '0;
        end
        else
        begin
            item.kind = in_range ? ITEM_LOAD : ITEM_DROP;
            item.ax   = VEC_W'(end_ax) - VEC_W'(end_bx);
            item.ay   = VEC_W'(end_ay) - VEC_W'(end_by);
            item.az   = VEC_W'(end_az) - VEC_W'(end_bz);
            item.bx   = VEC_W'(end_ax) + VEC_W'(end_bx);
            item.by   = VEC_W'(end_ay) + VEC_W'(end_by);
            item.bz   = VEC_W'(end_az) + VEC_W'(end_bz);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bsfs_queue.sv
`default_nettype none

module bsfs_queue
    import bsfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  work_item_t wr_item,
    output logic       q_full,
    input  logic       rd_en,
    output work_item_t rd_item,
    output logic       q_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_item_t       slot_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_empty = count_reg == '0;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bsfs_engine.sv
`default_nettype none

module bsfs_engine
    import bsfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  work_item_t                head,
    input  logic                      head_empty,
    output logic                      head_pop,
    input  logic [CFG_W-1:0]          segments_in_use,
    input  logic                      result_pop,
    output logic                      result_empty,
    output logic signed [FIELD_W-1:0] field_x,
    output logic signed [FIELD_W-1:0] field_y,
    output logic signed [FIELD_W-1:0] field_z,
    output logic                      singular
);

    localparam int MAG_W      = VEC_W;
    localparam int NORM_BITS  = 20;
    localparam int NRM_W      = NORM_BITS + 1;
    localparam int EXP_W      = 6;
    localparam int SH_W       = 8;
    localparam int SQ_W       = 2 * NRM_W;
    localparam int SQRT_W     = SQ_W + 1;
    localparam int CRS_W      = SQ_W + 1;
    localparam int D_W        = SQ_W + NRM_W;
    localparam int DREM_W     = D_W + 1;
    localparam int DIV_BITS   = 48;
    localparam int SCALE_W    = 32;
    localparam int PM_W       = 64;
    localparam int ACC_W      = 64;
    localparam int STEP_W     = 4;
    localparam int LAST_STEP  = 8;
    localparam int DCNT_W     = 6;
    localparam int SHIFT_BIAS = 61;
    localparam int CMP_W      = CFG_W + COUNT_W;

    localparam logic [MAG_W-1:0]        NORM_HI   = MAG_W'(1) << NORM_BITS;
    localparam logic [MAG_W-1:0]        NORM_LO   = MAG_W'(1) << (NORM_BITS - 1);
    localparam logic [PM_W-1:0]         TERM_CAP  = PM_W'(1) << FIELD_W;
    localparam logic [SCALE_W-1:0]      SCALE_1E7 = 32'd3602879702;
    localparam logic signed [ACC_W-1:0] OUT_MAX   = (ACC_W'(1) << (FIELD_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] OUT_MIN   = -OUT_MAX - ACC_W'(1);

    function automatic logic [MAG_W-1:0] max3(input logic [MAG_W-1:0] a,
                                              input logic [MAG_W-1:0] b,
                                              input logic [MAG_W-1:0] c);
        logic [MAG_W-1:0] m;
        begin
            m = a;
            if (b > m)
            begin
                m = b;
            end
            if (c > m)
            begin
                m = c;
            end
            max3 = m;
        end
    endfunction

    function automatic logic signed [NRM_W-1:0] norm_apply(input logic [MAG_W-1:0] mag,
                                                           input logic signed [EXP_W-1:0] ex,
                                                           input logic neg);
        logic [MAG_W-1:0]        shifted;
        logic [EXP_W-1:0]        amt;
        logic signed [NRM_W-1:0] val;
        begin
            if (ex >= 0)
            begin
                amt     = $unsigned(ex);
                shifted = mag >> amt;
            end
            else
            begin
                amt     = $unsigned(-ex);
                shifted = mag << amt;
            end
            val        = $signed(NRM_W'(shifted));
            norm_apply = neg ? -val : val;
        end
    endfunction

    function automatic logic signed [FIELD_W-1:0] saturate(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        begin
            s = v;
            if (v > OUT_MAX)
            begin
                s = OUT_MAX;
            end
            else if (v < OUT_MIN)
            begin
                s = OUT_MIN;
            end
            saturate = s[FIELD_W-1:0];
        end
    endfunction

    engine_state_t state_reg;
    engine_state_t state_next;

    logic [COUNT_W-1:0] seg_reg;
    logic [COUNT_W-1:0] seg_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [1:0]         k_reg;
    logic [1:0]         k_next;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [DCNT_W-1:0]  dcnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    seg_entry_t             seg_mem [MAX_SEGMENTS];
    seg_entry_t             rd_data_reg;
    seg_entry_t             wr_data;
    logic                   mem_wr;
    logic                   mem_rd;
    logic [SEG_IDX_W-1:0]   wr_addr;
    logic                   start_eval;
    logic                   result_load;

    logic [COUNT_W-1:0]      n_reg;
    logic [COUNT_W-1:0]      n_clamped;
    logic signed [VEC_W-1:0] pt_reg   [3];
    logic signed [VEC_W-1:0] r_reg    [3];
    logic signed [VEC_W-1:0] dl_reg   [3];
    logic [MAG_W-1:0]        rm_reg   [3];
    logic [MAG_W-1:0]        lm_reg   [3];
    logic                    rneg_reg [3];
    logic                    lneg_reg [3];
    logic [MAG_W-1:0]        rmax_reg;
    logic [MAG_W-1:0]        lmax_reg;
    logic signed [EXP_W-1:0] rex_reg;
    logic signed [EXP_W-1:0] lex_reg;
    logic signed [NRM_W-1:0] rn_reg   [3];
    logic signed [NRM_W-1:0] ln_reg   [3];
    logic signed [SH_W-1:0]  sh_reg;
    logic [SQ_W-1:0]         s_reg;
    logic signed [SQ_W-1:0]  p_reg;
    logic signed [CRS_W-1:0] c_reg    [3];
    logic [SQRT_W-1:0]       sq_rem_reg;
    logic [SQRT_W-1:0]       root_reg;
    logic [SQRT_W-1:0]       bit_reg;
    logic [D_W-1:0]          d_reg;
    logic [DREM_W-1:0]       drem_reg [3];
    logic [DIV_BITS-1:0]     q_reg    [3];
    logic [PM_W-1:0]         pm_reg;
    logic signed [ACC_W-1:0] acc_reg  [3];
    logic                    sing_reg;
    logic signed [FIELD_W-1:0] field_x_reg;
    logic signed [FIELD_W-1:0] field_y_reg;
    logic signed [FIELD_W-1:0] field_z_reg;
    logic                    singular_reg;

    logic                    r_zero;
    logic                    l_zero;
    logic                    r_hi;
    logic                    r_lo;
    logic                    l_hi;
    logic                    l_lo;
    logic                    norm_done;
    logic signed [NRM_W-1:0] mul_a;
    logic signed [NRM_W-1:0] mul_b;
    logic signed [SQ_W-1:0]  prod;
    logic [SQRT_W-1:0]       sq_trial;
    logic [PM_W-1:0]         cap_sh;
    logic [PM_W-1:0]         half;
    logic [PM_W-1:0]         t_mag;
    logic [PM_W-1:0]         t_signed;
    logic [SH_W-1:0]         rs;

    assign n_clamped = (CMP_W'(segments_in_use) > CMP_W'(MAX_SEGMENTS))
                       ? COUNT_W'(MAX_SEGMENTS) : COUNT_W'(segments_in_use);

    assign r_zero    = (r_reg[0] == '0) && (r_reg[1] == '0) && (r_reg[2] == '0);
    assign l_zero    = (dl_reg[0] == '0) && (dl_reg[1] == '0) && (dl_reg[2] == '0);
    assign r_hi      = rmax_reg >= NORM_HI;
    assign r_lo      = rmax_reg < NORM_LO;
    assign l_hi      = lmax_reg >= NORM_HI;
    assign l_lo      = lmax_reg < NORM_LO;
    assign norm_done = !r_hi && !r_lo && !l_hi && !l_lo;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!head_empty && head.kind == ITEM_EVAL)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:  state_next = (seg_reg == n_reg) ? S_FINISH : S_CHECK;
            S_CHECK:  state_next = S_MAG;
            S_MAG:    state_next = (r_zero || l_zero) ? S_FETCH : S_MAX;
            S_MAX:    state_next = S_NORM;
            S_NORM:   state_next = norm_done ? S_APPLY : S_NORM;
            S_APPLY:  state_next = S_MUL;
            S_MUL:    state_next = (step_reg == STEP_W'(LAST_STEP)) ? S_SQRT : S_MUL;
            S_SQRT:   state_next = bit_reg[0] ? S_CUBE1 : S_SQRT;
            S_CUBE1:  state_next = S_CUBE2;
            S_CUBE2:  state_next = S_DIV;
            S_DIV:    state_next = (dcnt_reg == DCNT_W'(DIV_BITS - 1)) ? S_SCALE : S_DIV;
            S_SCALE:  state_next = S_SHIFT;
            S_SHIFT:  state_next = (k_reg == 2'd2) ? S_FETCH : S_SCALE;
            S_FINISH:
            begin
                if (!out_valid_reg || result_pop)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        head_pop    = (state_reg == S_IDLE) && !head_empty;
        mem_wr      = head_pop && head.kind == ITEM_LOAD;
        start_eval  = head_pop && head.kind == ITEM_EVAL;
        mem_rd      = (state_reg == S_FETCH) && (seg_reg != n_reg);
        result_load = (state_reg == S_FINISH) && (!out_valid_reg || result_pop);

        seg_next = seg_reg;
        if (start_eval)
        begin
            seg_next = '0;
        end
        else if ((state_reg == S_MAG && (r_zero || l_zero))
                 || (state_reg == S_SHIFT && k_reg == 2'd2))
        begin
            seg_next = seg_reg + 1'b1;
        end

        step_next = step_reg;
        if (state_reg == S_APPLY)
        begin
            step_next = '0;
        end
        else if (state_reg == S_MUL)
        begin
            step_next = step_reg + 1'b1;
        end

        dcnt_next = dcnt_reg;
        if (state_reg == S_CUBE2)
        begin
            dcnt_next = '0;
        end
        else if (state_reg == S_DIV)
        begin
            dcnt_next = dcnt_reg + 1'b1;
        end

        k_next = k_reg;
        if (state_reg == S_CUBE2)
        begin
            k_next = '0;
        end
        else if (state_reg == S_SHIFT)
        begin
            k_next = (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_reg       <= '0;
            step_reg      <= '0;
            k_reg         <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign wr_addr       = SEG_IDX_W'(head.idx);
    assign wr_data.dir_x = head.ax;
    assign wr_data.dir_y = head.ay;
    assign wr_data.dir_z = head.az;
    assign wr_data.mid_x = head.bx;
    assign wr_data.mid_y = head.by;
    assign wr_data.mid_z = head.bz;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            seg_mem[wr_addr] <= wr_data;
        end
        if (mem_rd)
        begin
            rd_data_reg <= seg_mem[seg_reg[SEG_IDX_W-1:0]];
        end
    end

    always_comb
    begin
        unique case (step_reg)
            4'd0:    begin mul_a = rn_reg[0]; mul_b = rn_reg[0]; end
            4'd1:    begin mul_a = rn_reg[1]; mul_b = rn_reg[1]; end
            4'd2:    begin mul_a = rn_reg[2]; mul_b = rn_reg[2]; end
            4'd3:    begin mul_a = ln_reg[1]; mul_b = rn_reg[2]; end
            4'd4:    begin mul_a = ln_reg[2]; mul_b = rn_reg[1]; end
            4'd5:    begin mul_a = ln_reg[2]; mul_b = rn_reg[0]; end
            4'd6:    begin mul_a = ln_reg[0]; mul_b = rn_reg[2]; end
            4'd7:    begin mul_a = ln_reg[0]; mul_b = rn_reg[1]; end
            4'd8:    begin mul_a = ln_reg[1]; mul_b = rn_reg[0]; end
            default: begin mul_a = '0;        mul_b = '0;        end
        endcase
    end

    assign prod     = SQ_W'(mul_a) * SQ_W'(mul_b);
    assign sq_trial = root_reg + bit_reg;

    always_comb
    begin
        cap_sh = '0;
        half   = '0;
        rs     = '0;
        if (!sh_reg[SH_W-1])
        begin
            cap_sh = TERM_CAP >> $unsigned(sh_reg);
            t_mag  = (pm_reg > cap_sh) ? TERM_CAP : (pm_reg << $unsigned(sh_reg));
        end
        else
        begin
            rs = $unsigned(-sh_reg);
            if (rs >= SH_W'(PM_W))
            begin
                t_mag = '0;
            end
            else
            begin
                // Round half up on the magnitude.
                half  = pm_reg >> (rs - SH_W'(1));
                t_mag = (pm_reg >> rs) + PM_W'(half[0]);
            end
        end
        t_signed = c_reg[k_reg][CRS_W-1] ? -t_mag : t_mag;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start_eval)
                begin
                    n_reg     <= n_clamped;
                    pt_reg[0] <= head.ax;
                    pt_reg[1] <= head.ay;
                    pt_reg[2] <= head.az;
                    sing_reg  <= 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        acc_reg[i] <= '0;
                    end
                end
            end
            S_CHECK:
            begin
                r_reg[0]  <= pt_reg[0] - rd_data_reg.mid_x;
                r_reg[1]  <= pt_reg[1] - rd_data_reg.mid_y;
                r_reg[2]  <= pt_reg[2] - rd_data_reg.mid_z;
                dl_reg[0] <= rd_data_reg.dir_x;
                dl_reg[1] <= rd_data_reg.dir_y;
                dl_reg[2] <= rd_data_reg.dir_z;
            end
            S_MAG:
            begin
                if (r_zero)
                begin
                    sing_reg <= 1'b1;
                end
                for (int i = 0; i < 3; i++)
                begin
                    rneg_reg[i] <= r_reg[i][VEC_W-1];
                    lneg_reg[i] <= dl_reg[i][VEC_W-1];
                    rm_reg[i]   <= $unsigned(r_reg[i][VEC_W-1] ? -r_reg[i] : r_reg[i]);
                    lm_reg[i]   <= $unsigned(dl_reg[i][VEC_W-1] ? -dl_reg[i] : dl_reg[i]);
                end
            end
            S_MAX:
            begin
                rmax_reg <= max3(rm_reg[0], rm_reg[1], rm_reg[2]);
                lmax_reg <= max3(lm_reg[0], lm_reg[1], lm_reg[2]);
                rex_reg  <= '0;
                lex_reg  <= '0;
            end
            S_NORM:
            begin
                if (r_hi)
                begin
                    rmax_reg <= rmax_reg >> 1;
                    rex_reg  <= rex_reg + EXP_W'(1);
                end
                else if (r_lo)
                begin
                    rmax_reg <= rmax_reg << 1;
                    rex_reg  <= rex_reg - EXP_W'(1);
                end
                if (l_hi)
                begin
                    lmax_reg <= lmax_reg >> 1;
                    lex_reg  <= lex_reg + EXP_W'(1);
                end
                else if (l_lo)
                begin
                    lmax_reg <= lmax_reg << 1;
                    lex_reg  <= lex_reg - EXP_W'(1);
                end
            end
            S_APPLY:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rn_reg[i] <= norm_apply(rm_reg[i], rex_reg, rneg_reg[i]);
                    ln_reg[i] <= norm_apply(lm_reg[i], lex_reg, lneg_reg[i]);
                end
                sh_reg <= SH_W'(int'(lex_reg) - 2 * int'(rex_reg)
                                + COORD_FRAC_BITS - SHIFT_BIAS);
            end
            S_MUL:
            begin
                unique case (step_reg)
                    4'd0:          s_reg <= $unsigned(prod);
                    4'd1, 4'd2:    s_reg <= s_reg + $unsigned(prod);
                    4'd3, 4'd5, 4'd7: p_reg <= prod;
                    4'd4:          c_reg[0] <= CRS_W'(p_reg) - CRS_W'(prod);
                    4'd6:          c_reg[1] <= CRS_W'(p_reg) - CRS_W'(prod);
                    4'd8:
                    begin
                        c_reg[2]   <= CRS_W'(p_reg) - CRS_W'(prod);
                        sq_rem_reg <= SQRT_W'(s_reg);
                        root_reg   <= '0;
                        bit_reg    <= SQRT_W'(1) << (SQRT_W - 1);
                    end
                    default: ;
                endcase
            end
            S_SQRT:
            begin
                if (sq_rem_reg >= sq_trial)
                begin
                    sq_rem_reg <= sq_rem_reg - sq_trial;
                    root_reg   <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            S_CUBE1:
            begin
                d_reg <= D_W'(SQ_W'(root_reg[NRM_W-1:0]) * SQ_W'(root_reg[NRM_W-1:0]));
            end
            S_CUBE2:
            begin
                d_reg <= D_W'(d_reg[SQ_W-1:0]) * D_W'(root_reg[NRM_W-1:0]);
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= DREM_W'($unsigned(c_reg[i][CRS_W-1] ? -c_reg[i] : c_reg[i]));
                    q_reg[i]    <= '0;
                end
            end
            S_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if ({drem_reg[i][DREM_W-2:0], 1'b0} >= DREM_W'(d_reg))
                    begin
                        drem_reg[i] <= {drem_reg[i][DREM_W-2:0], 1'b0} - DREM_W'(d_reg);
                        q_reg[i]    <= {q_reg[i][DIV_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[i] <= {drem_reg[i][DREM_W-2:0], 1'b0};
                        q_reg[i]    <= {q_reg[i][DIV_BITS-2:0], 1'b0};
                    end
                end
            end
            S_SCALE:
            begin
                pm_reg <= PM_W'(q_reg[k_reg][SCALE_W-1:0]) * PM_W'(SCALE_1E7);
            end
            S_SHIFT:
            begin
                acc_reg[k_reg] <= acc_reg[k_reg] + $signed(t_signed);
            end
            S_FINISH:
            begin
                if (result_load)
                begin
                    field_x_reg  <= saturate(acc_reg[0]);
                    field_y_reg  <= saturate(acc_reg[1]);
                    field_z_reg  <= saturate(acc_reg[2]);
                    singular_reg <= sing_reg;
                end
            end
            default: ;
        endcase
    end

    assign result_empty = !out_valid_reg;
    assign field_x      = field_x_reg;
    assign field_y      = field_y_reg;
    assign field_z      = field_z_reg;
    assign singular     = singular_reg;

endmodule

`default_nettype wire

// File: rtl/core/biot_savart_field_sum.sv
// Channel    Direction  Transfer when          Carries
// config     in/out     psel&penable&pwrite    segments_in_use at byte address 0
// items      in         push & !full           mode, seg_index, ends, point
// results    out        pop & !empty           field_x/y/z, singular
//
// With the engine idle, a segment load passes through the queue and is written to the segment
// memory when the engine takes it from the queue.
// A field point is summed over the segments in use, with normalising shifts, the 48-step
// divider and the 22-step square root as the longest parts of each segment's work. A segment
// whose midpoint is the point, or whose direction is zero, is skipped; the former sets singular.
// Reset clears the control state only; the segment memory holds nothing until loaded.
// A two-entry queue takes items while a field point is being summed, and a finished result
// waits in its output register without blocking loads.
`default_nettype none

module biot_savart_field_sum
    import bsfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      push,
    output logic                      full,
    input  logic                      mode,
    input  logic [INDEX_W-1:0]        seg_index,
    input  logic signed [COORD_W-1:0] end_ax,
    input  logic signed [COORD_W-1:0] end_bx,
    input  logic signed [COORD_W-1:0] end_ay,
    input  logic signed [COORD_W-1:0] end_by,
    input  logic signed [COORD_W-1:0] end_az,
    input  logic signed [COORD_W-1:0] end_bz,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic                      pop,
    output logic                      empty,
    output logic signed [FIELD_W-1:0] field_x,
    output logic signed [FIELD_W-1:0] field_y,
    output logic signed [FIELD_W-1:0] field_z,
    output logic                      singular
);

    logic [CFG_W-1:0] seg_count_reg;
    logic [CFG_W-1:0] seg_count_next;
    logic             reg_hit;
    work_item_t       front_item;
    work_item_t       head_item;
    logic             head_empty;
    logic             head_pop;

    assign pready  = 1'b1;
    assign reg_hit = paddr[PADDR_W-1:2] == REG_SEGMENTS_IN_USE;
    assign prdata  = reg_hit ? APB_DATA_W'(seg_count_reg) : '0;

    always_comb
    begin
        seg_count_next = seg_count_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            seg_count_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= SEGMENTS_RESET;
        end
        else
        begin
            seg_count_reg <= seg_count_next;
        end
    end

    bsfs_front u_front (
        .mode      (mode),
        .seg_index (seg_index),
        .end_ax    (end_ax),
        .end_bx    (end_bx),
        .end_ay    (end_ay),
        .end_by    (end_by),
        .end_az    (end_az),
        .end_bz    (end_bz),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .item      (front_item)
    );

    bsfs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_item (front_item),
        .q_full  (full),
        .rd_en   (head_pop),
        .rd_item (head_item),
        .q_empty (head_empty)
    );

    bsfs_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head_item),
        .head_empty      (head_empty),
        .head_pop        (head_pop),
        .segments_in_use (seg_count_reg),
        .result_pop      (pop),
        .result_empty    (empty),
        .field_x         (field_x),
        .field_y         (field_y),
        .field_z         (field_z),
        .singular        (singular)
    );

endmodule

`default_nettype wire
